@@ hw/rtl/grid_point_splat_linear_falloff_top_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef GRID_POINT_SPLAT_LINEAR_FALLOFF_TOP_MACROS_SVH
`define GRID_POINT_SPLAT_LINEAR_FALLOFF_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define GPSL_ASSERT_CLK(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define GPSL_ASSERT(lbl, prop, msg) `GPSL_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define GPSL_ASSERT_CLK(lbl, ck, rn, prop, msg)
`define GPSL_ASSERT(lbl, prop, msg)
`endif

`endif

@@ hw/rtl/gpsl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gpsl_pkg;

    localparam int MAX_X = 16;
    localparam int MAX_Y = 16;
    localparam int MAX_Z = 16;
    localparam int MAX_A = (MAX_X > MAX_Y) ? ((MAX_X > MAX_Z) ? MAX_X : MAX_Z)
                                          : ((MAX_Y > MAX_Z) ? MAX_Y : MAX_Z);
    localparam int CW     = $clog2(MAX_A + 1);
    localparam int DEPTH  = MAX_X * MAX_Y * MAX_Z;
    localparam int AW     = $clog2(DEPTH);

    localparam int NUM_REGS = 5;
    localparam int PADDR_W  = $clog2(4 * NUM_REGS);
    localparam int SCALE_MAX = 1000;

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);

    localparam logic CMD_SPLAT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [2:0] REG_SIZE_X = 3'd0;
    localparam logic [2:0] REG_SIZE_Y = 3'd1;
    localparam logic [2:0] REG_SIZE_Z = 3'd2;
    localparam logic [2:0] REG_SCALE  = 3'd3;
    localparam logic [2:0] REG_DECAY  = 3'd4;

    localparam logic signed [24:0] CELL_MAX = 25'sd8388607;
    localparam logic [12:0] COUNT_MAX = 13'd8191;

    typedef struct packed {
        logic              cmd;
        logic [15:0]       point_x;
        logic [15:0]       point_y;
        logic [15:0]       point_z;
        logic signed [15:0] activity;
        logic [3:0]        cell_x;
        logic [3:0]        cell_y;
        logic [3:0]        cell_z;
    } in_t;

    typedef struct packed {
        logic signed [23:0] cell_value;
        logic [12:0]        cells_updated;
        logic               saturated;
        logic               not_found;
    } out_t;

    typedef struct packed {
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] sz;
        logic [9:0]    scale;
        logic [15:0]   decay;
    } cfg_t;

    typedef struct packed {
        in_t  item;
        logic oob;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                                 input logic [CW-1:0] y,
                                                 input logic [CW-1:0] z);
        logic [AW+CW-1:0] t;
        t = (AW+CW)'(x) * (AW+CW)'(MAX_Y) + (AW+CW)'(y);
        t = t * (AW+CW)'(MAX_Z) + (AW+CW)'(z);
        return t[AW-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/grid_point_splat_linear_falloff_top.sv @@
//  channel   direction  handshake                 payload
//  command   in         start, accepted !busy     item   (gpsl_pkg::in_t)
//  result    out        done, one-cycle strobe    result (gpsl_pkg::out_t)
//  config    in/out     APB psel/penable/pready   paddr, pwdata, prdata
//
//  A read passes through states S_RDA and S_RDO before its result goes out.
//  A splat does its setup with a 33-step divide, then for each cell in its box
//  a 27-step square root and, for cells in reach, a 33-step divide on the
//  shared divider.
//  After reset the grid is cleared one cell per cycle, all 4096 cells, with busy high.
//  A two-entry queue takes commands while a splat runs; results cannot be held off.
`timescale 1ns / 1ps
`default_nettype none

module grid_point_splat_linear_falloff_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  gpsl_pkg::in_t                item,
    output logic                         done,
    output gpsl_pkg::out_t               result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gpsl_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [4:0]  size_x_reg;
    logic [4:0]  size_y_reg;
    logic [4:0]  size_z_reg;
    logic [9:0]  scale_reg;
    logic [15:0] decay_reg;
    logic [2:0]  idx;
    logic        wr;

    gpsl_pkg::cfg_t  cfg;
    gpsl_pkg::head_t head;
    logic            pop;
    logic            clearing;

    function automatic logic [gpsl_pkg::CW-1:0] clamp_sz(input logic [4:0] v,
                                                         input int hi);
        if (v == 5'd0)
        begin
            return gpsl_pkg::CW'(1);
        end
        if (int'(v) > hi)
        begin
            return gpsl_pkg::CW'(hi);
        end
        return gpsl_pkg::CW'(v);
    endfunction

    assign pready = 1'b1;
    assign idx    = paddr[gpsl_pkg::PADDR_W-1:2];
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= 5'd16;
            size_y_reg <= 5'd16;
            size_z_reg <= 5'd16;
            scale_reg  <= 10'd1;
            decay_reg  <= 16'd256;
        end
        else if (wr)
        begin
            case (idx)
                gpsl_pkg::REG_SIZE_X: size_x_reg <= pwdata[4:0];
                gpsl_pkg::REG_SIZE_Y: size_y_reg <= pwdata[4:0];
                gpsl_pkg::REG_SIZE_Z: size_z_reg <= pwdata[4:0];
                gpsl_pkg::REG_SCALE:  scale_reg  <= pwdata[9:0];
                gpsl_pkg::REG_DECAY:  decay_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            gpsl_pkg::REG_SIZE_X: prdata = 32'(size_x_reg);
            gpsl_pkg::REG_SIZE_Y: prdata = 32'(size_y_reg);
            gpsl_pkg::REG_SIZE_Z: prdata = 32'(size_z_reg);
            gpsl_pkg::REG_SCALE:  prdata = 32'(scale_reg);
            gpsl_pkg::REG_DECAY:  prdata = 32'(decay_reg);
            default:              prdata = 32'd0;
        endcase
    end

    assign cfg.sx    = clamp_sz(size_x_reg, gpsl_pkg::MAX_X);
    assign cfg.sy    = clamp_sz(size_y_reg, gpsl_pkg::MAX_Y);
    assign cfg.sz    = clamp_sz(size_z_reg, gpsl_pkg::MAX_Z);
    assign cfg.scale = (scale_reg == 10'd0) ? 10'd1
                     : (scale_reg > 10'(gpsl_pkg::SCALE_MAX)) ? 10'(gpsl_pkg::SCALE_MAX)
                     : scale_reg;
    assign cfg.decay = (decay_reg == 16'd0) ? 16'd1 : decay_reg;

    gpsl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .cfg      (cfg),
        .clearing (clearing),
        .pop      (pop),
        .busy     (busy),
        .head     (head)
    );

    gpsl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .head     (head),
        .pop      (pop),
        .clearing (clearing),
        .done     (done),
        .result   (result)
    );

endmodule

`default_nettype wire

@@ hw/rtl/gpsl_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gpsl_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] num,
    input  logic [15:0] den,
    output logic        done,
    output logic [32:0] quo
);

    logic [32:0] a_reg;
    logic [15:0] rem_reg;
    logic [15:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [16:0] trial;
    logic        ge;

    assign trial = {rem_reg, a_reg[32]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd32)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            a_reg   <= {a_reg[31:0], ge};
            rem_reg <= ge ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
        end
    end

    assign done = done_reg;
    assign quo  = a_reg;

endmodule

`default_nettype wire

@@ hw/rtl/gpsl_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gpsl_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [53:0] n,
    output logic        done,
    output logic [26:0] root
);

    logic [53:0] n_reg;
    logic [53:0] res_reg;
    logic [53:0] bit_reg;
    logic        run_reg;
    logic        done_reg;
    logic [53:0] t;

    assign t = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && bit_reg[0])
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= n;
            res_reg <= '0;
            bit_reg <= 54'd1 << 52;
        end
        else if (run_reg)
        begin
            if (n_reg >= t)
            begin
                n_reg   <= n_reg - t;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[26:0];

endmodule

`default_nettype wire

@@ hw/rtl/gpsl_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gpsl_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  gpsl_pkg::in_t   item,
    input  gpsl_pkg::cfg_t  cfg,
    input  logic            clearing,
    input  logic            pop,
    output logic            busy,
    output gpsl_pkg::head_t head
);

    gpsl_pkg::entry_t          q_reg [gpsl_pkg::QDEPTH];
    logic [gpsl_pkg::QPW-1:0]  wr_ptr_reg;
    logic [gpsl_pkg::QPW-1:0]  rd_ptr_reg;
    logic [gpsl_pkg::QPW:0]    cnt_reg;
    logic                      push;
    logic                      full;
    logic                      oob;

    assign full = cnt_reg == (gpsl_pkg::QPW+1)'(gpsl_pkg::QDEPTH);
    assign busy = full || clearing;
    assign push = start && !busy;

    assign oob = ((gpsl_pkg::CW+4)'(item.cell_x) >= (gpsl_pkg::CW+4)'(cfg.sx))
              || ((gpsl_pkg::CW+4)'(item.cell_y) >= (gpsl_pkg::CW+4)'(cfg.sy))
              || ((gpsl_pkg::CW+4)'(item.cell_z) >= (gpsl_pkg::CW+4)'(cfg.sz));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == gpsl_pkg::QPW'(gpsl_pkg::QDEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == gpsl_pkg::QPW'(gpsl_pkg::QDEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{item: item, oob: oob};
        end
    end

    assign head.valid = cnt_reg != '0;
    assign head.entry = q_reg[rd_ptr_reg];

`include "grid_point_splat_linear_falloff_top_macros.svh"

    `GPSL_ASSERT(a_cnt_bound, cnt_reg <= (gpsl_pkg::QPW+1)'(gpsl_pkg::QDEPTH), "queue overrun")
    `GPSL_ASSERT(a_pop_empty, pop |=> (cnt_reg != '0) || !$past(cnt_reg == '0), "pop on empty")
    `GPSL_ASSERT(a_busy_clear, clearing |-> busy, "busy low during clear")

endmodule

`default_nettype wire

@@ hw/rtl/gpsl_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gpsl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  gpsl_pkg::cfg_t  cfg,
    input  gpsl_pkg::head_t head,
    output logic            pop,
    output logic            clearing,
    output logic            done,
    output gpsl_pkg::out_t  result
);

    typedef enum logic [16:0] {
        S_CLR   = 17'h00001,
        S_IDLE  = 17'h00002,
        S_RDA   = 17'h00004,
        S_RDO   = 17'h00008,
        S_PRE   = 17'h00010,
        S_RDIV  = 17'h00020,
        S_BOX1  = 17'h00040,
        S_BOX2  = 17'h00080,
        S_BOX3  = 17'h00100,
        S_CELL  = 17'h00200,
        S_SQ    = 17'h00400,
        S_SUM   = 17'h00800,
        S_SQRT  = 17'h01000,
        S_LOSS  = 17'h02000,
        S_CMP   = 17'h04000,
        S_LDIV  = 17'h08000,
        S_WR    = 17'h10000
    } state_t;

    state_t state_reg, state_next;
    logic   fin_reg;

    logic [23:0]             mem [gpsl_pkg::DEPTH];
    logic [23:0]             mem_q_reg;
    logic [gpsl_pkg::AW-1:0] clr_reg;
    logic [gpsl_pkg::AW-1:0] addr;
    logic                    we;
    logic [gpsl_pkg::AW-1:0] waddr;
    logic [23:0]             wdata;

    logic [gpsl_pkg::CW-1:0] pos_reg [3];
    logic [gpsl_pkg::CW-1:0] lo_reg [3];
    logic [gpsl_pkg::CW-1:0] hi_reg [3];
    logic [25:0]             p_reg [3];
    logic signed [34:0]      v_reg [3];
    logic signed [34:0]      corner_reg [3];
    logic signed [34:0]      rad_reg;
    logic [25:0]             adx_reg [3];
    logic [51:0]             sq_reg [3];
    logic [24:0]             actsc_reg;
    logic [32:0]             r_reg;
    logic [42:0]             prod_reg;
    logic [15:0]             gain_reg;
    logic signed [15:0]      act_reg;
    logic                    oob_reg;
    logic [12:0]             cnt_reg;
    logic                    sat_reg;
    logic                    done_reg;
    gpsl_pkg::out_t          out_reg;

    logic        div_start, div_done, sq_start, sq_done;
    logic [32:0] div_num, div_quo;
    logic [15:0] div_den;
    logic [26:0] root;
    logic [53:0] sq_n;
    logic [34:0] q;
    logic        gain_zero;

    logic signed [34:0]      far [3];
    logic signed [34:0]      lo_t [3];
    logic signed [34:0]      hi_t [3];
    logic signed [34:0]      szs [3];
    logic [2:0]              emp;
    logic signed [26:0]      dx [3];
    logic [gpsl_pkg::CW:0]   nxt [3];
    logic [2:0]              more;
    logic signed [24:0]      sum;

    function automatic logic signed [34:0] rnd(input logic signed [34:0] v);
        logic signed [34:0] m;
        logic signed [34:0] t;
        m = v[34] ? -v : v;
        t = (m + 35'sd128) >>> 8;
        return v[34] ? -t : t;
    endfunction

    assign pop      = (state_reg == S_IDLE) && head.valid;
    assign clearing = state_reg == S_CLR;
    assign q        = prod_reg[42:8];
    assign gain_zero = q >= 35'(actsc_reg);

    assign div_start = (state_reg == S_PRE) || ((state_reg == S_CMP) && !gain_zero);
    assign div_num   = (state_reg == S_PRE) ? {actsc_reg, 8'b0} : {8'b0, q[24:0]};
    assign div_den   = (state_reg == S_PRE) ? cfg.decay : {6'b0, cfg.scale};
    assign sq_start  = state_reg == S_SUM;
    assign sq_n      = 54'(sq_reg[0]) + 54'(sq_reg[1]) + 54'(sq_reg[2]);

    gpsl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    gpsl_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .n     (sq_n),
        .done  (sq_done),
        .root  (root)
    );

    assign szs[0] = 35'(cfg.sx);
    assign szs[1] = 35'(cfg.sy);
    assign szs[2] = 35'(cfg.sz);

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            far[a]  = corner_reg[a] + (rad_reg <<< 1);
            lo_t[a] = corner_reg[a][34] ? 35'sd0 : corner_reg[a];
            hi_t[a] = (far[a] < szs[a]) ? far[a] : szs[a];
            emp[a]  = (far[a] <= lo_t[a]) || (szs[a] <= lo_t[a]);
            dx[a]   = $signed(27'({pos_reg[a], 8'b0})) - $signed({1'b0, p_reg[a]});
            nxt[a]  = (gpsl_pkg::CW+1)'(pos_reg[a]) + 1'b1;
            more[a] = nxt[a] < (gpsl_pkg::CW+1)'(hi_reg[a]);
        end
    end

    assign sum = $signed({mem_q_reg[23], mem_q_reg}) + $signed({9'b0, gain_reg});

    assign addr  = gpsl_pkg::cell_addr(pos_reg[0], pos_reg[1], pos_reg[2]);
    assign we    = (state_reg == S_CLR) || (state_reg == S_WR);
    assign waddr = (state_reg == S_CLR) ? clr_reg : addr;
    assign wdata = (state_reg == S_CLR) ? 24'd0
                 : (sum > gpsl_pkg::CELL_MAX) ? 24'h7FFFFF : sum[23:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (clr_reg == gpsl_pkg::AW'(gpsl_pkg::DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.entry.item.cmd == gpsl_pkg::CMD_READ)
                    begin
                        state_next = S_RDA;
                    end
                    else if (head.entry.item.activity > 16'sd0)
                    begin
                        state_next = S_PRE;
                    end
                end
            end
            S_RDA:  state_next = S_RDO;
            S_RDO:  state_next = S_IDLE;
            S_PRE:  state_next = S_RDIV;
            S_RDIV:
            begin
                if (div_done)
                begin
                    state_next = S_BOX1;
                end
            end
            S_BOX1: state_next = S_BOX2;
            S_BOX2: state_next = S_BOX3;
            S_BOX3: state_next = (emp != 3'b0) ? S_IDLE : S_CELL;
            S_CELL: state_next = S_SQ;
            S_SQ:   state_next = S_SUM;
            S_SUM:  state_next = S_SQRT;
            S_SQRT:
            begin
                if (sq_done)
                begin
                    state_next = S_LOSS;
                end
            end
            S_LOSS: state_next = S_CMP;
            S_CMP:  state_next = gain_zero ? S_WR : S_LDIV;
            S_LDIV:
            begin
                if (div_done)
                begin
                    state_next = S_WR;
                end
            end
            S_WR:   state_next = (more != 3'b0) ? S_CELL : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // fin_reg marks a splat whose result goes out when the walk or setup ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            cnt_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (state_reg == S_CLR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (pop)
            begin
                cnt_reg <= '0;
                sat_reg <= 1'b0;
            end
            if (state_reg == S_WR)
            begin
                if (cnt_reg != gpsl_pkg::COUNT_MAX)
                begin
                    cnt_reg <= cnt_reg + 13'd1;
                end
                if (sum > gpsl_pkg::CELL_MAX)
                begin
                    sat_reg <= 1'b1;
                end
            end
            fin_reg <= (pop && (head.entry.item.cmd == gpsl_pkg::CMD_SPLAT)
                        && !(head.entry.item.activity > 16'sd0))
                    || ((state_reg == S_BOX3) && (emp != 3'b0))
                    || ((state_reg == S_WR) && (more == 3'b0));
            if ((state_reg == S_RDO) || fin_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_q_reg <= mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            act_reg    <= head.entry.item.activity;
            oob_reg    <= head.entry.oob;
            p_reg[0]   <= head.entry.item.point_x * cfg.scale;
            p_reg[1]   <= head.entry.item.point_y * cfg.scale;
            p_reg[2]   <= head.entry.item.point_z * cfg.scale;
            actsc_reg  <= head.entry.item.activity[14:0] * cfg.scale;
            pos_reg[0] <= gpsl_pkg::CW'(head.entry.item.cell_x);
            pos_reg[1] <= gpsl_pkg::CW'(head.entry.item.cell_y);
            pos_reg[2] <= gpsl_pkg::CW'(head.entry.item.cell_z);
        end
        if ((state_reg == S_RDIV) && div_done)
        begin
            r_reg <= div_quo;
        end
        if (state_reg == S_BOX1)
        begin
            for (int a = 0; a < 3; a++)
            begin
                v_reg[a] <= $signed({9'b0, p_reg[a]}) - $signed({2'b0, r_reg}) + 35'sd128;
            end
        end
        if (state_reg == S_BOX2)
        begin
            for (int a = 0; a < 3; a++)
            begin
                corner_reg[a] <= rnd(v_reg[a]);
            end
            if (r_reg >= 33'd128)
            begin
                rad_reg <= 35'(r_reg >> 8);
            end
            else
            begin
                rad_reg <= (r_reg == 33'd0) ? -35'sd1 : 35'sd0;
            end
        end
        if (state_reg == S_BOX3)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo_reg[a]  <= lo_t[a][gpsl_pkg::CW-1:0];
                hi_reg[a]  <= hi_t[a][gpsl_pkg::CW-1:0];
                pos_reg[a] <= lo_t[a][gpsl_pkg::CW-1:0];
            end
        end
        if (state_reg == S_CELL)
        begin
            for (int a = 0; a < 3; a++)
            begin
                adx_reg[a] <= dx[a][26] ? 26'(-dx[a]) : dx[a][25:0];
            end
        end
        if (state_reg == S_SQ)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sq_reg[a] <= adx_reg[a] * adx_reg[a];
            end
        end
        if (state_reg == S_LOSS)
        begin
            prod_reg <= root * cfg.decay;
        end
        if ((state_reg == S_CMP) && gain_zero)
        begin
            gain_reg <= '0;
        end
        if ((state_reg == S_LDIV) && div_done)
        begin
            gain_reg <= act_reg - div_quo[15:0];
        end
        if (state_reg == S_WR)
        begin
            if (more[2])
            begin
                pos_reg[2] <= nxt[2][gpsl_pkg::CW-1:0];
            end
            else
            begin
                pos_reg[2] <= lo_reg[2];
                if (more[1])
                begin
                    pos_reg[1] <= nxt[1][gpsl_pkg::CW-1:0];
                end
                else
                begin
                    pos_reg[1] <= lo_reg[1];
                    pos_reg[0] <= nxt[0][gpsl_pkg::CW-1:0];
                end
            end
        end
        if (state_reg == S_RDO)
        begin
            out_reg.cell_value    <= oob_reg ? 24'sd0 : mem_q_reg;
            out_reg.cells_updated <= '0;
            out_reg.saturated     <= 1'b0;
            out_reg.not_found     <= oob_reg;
        end
        if (fin_reg)
        begin
            out_reg.cell_value    <= 24'sd0;
            out_reg.cells_updated <= cnt_reg;
            out_reg.saturated     <= sat_reg;
            out_reg.not_found     <= 1'b0;
        end
    end

    assign done   = done_reg;
    assign result = out_reg;

`include "grid_point_splat_linear_falloff_top_macros.svh"

    `GPSL_ASSERT(a_one_source, (state_reg == S_RDO) |-> !fin_reg, "read and splat result collide")
    `GPSL_ASSERT(a_gain_bound, (state_reg == S_WR) |-> (!act_reg[15] && (gain_reg <= act_reg)), "gain exceeds activity")
    `GPSL_ASSERT(a_walk_in_box, (state_reg == S_WR) |-> ((pos_reg[0] < hi_reg[0]) && (pos_reg[1] < hi_reg[1]) && (pos_reg[2] < hi_reg[2])), "walk left its box")
    `GPSL_ASSERT(a_clear_quiet, (state_reg == S_CLR) |-> (!pop && !fin_reg), "activity during clear")

endmodule

`default_nettype wire
